// ----- src/plir_pkg.sv -----
// ----------------------------------------------------------------------------
// plir_pkg
// Shared constants, types and the sample decoder for the resampler.
// ----------------------------------------------------------------------------
package plir_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int SAMPLE_BITS = 24;
    localparam int RAW_BITS    = 24;
    localparam int PHASE_BITS  = 21;
    localparam int STEP_BITS   = 20;
    localparam int MAX_RESULTS = 64;
    localparam int CNT_W       = $clog2(MAX_RESULTS) + 1;
    localparam int DIFF_W      = SAMPLE_BITS + 1;
    localparam int PROD_W      = DIFF_W + FRAC_BITS + 1;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = STEP_BITS;

    typedef logic [RAW_BITS-1:0]           raw_t;
    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic [PHASE_BITS-1:0]         phase_t;
    typedef logic [STEP_BITS-1:0]          step_t;
    typedef logic [1:0]                    width_t;
    typedef logic [CFG_IDX_W-1:0]          cfg_idx_t;
    typedef logic [CFG_DATA_W-1:0]         cfg_data_t;

    localparam width_t   WIDTH_U8  = 2'd0;
    localparam width_t   WIDTH_S16 = 2'd1;
    localparam width_t   WIDTH_S24 = 2'd2;

    localparam cfg_idx_t CFG_SAMPLE_WIDTH = 2'd0;
    localparam cfg_idx_t CFG_STEREO_MODE  = 2'd1;
    localparam cfg_idx_t CFG_PHASE_STEP   = 2'd2;

    localparam width_t   RST_SAMPLE_WIDTH = WIDTH_S16;
    localparam logic     RST_STEREO_MODE  = 1'b1;
    localparam step_t    RST_PHASE_STEP   = step_t'(1 << FRAC_BITS);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_CHECK = 3'b010,
        ST_EMIT  = 3'b100
    } state_t;

    typedef struct packed {
        logic load_in;
        logic step;
        logic emit;
        logic finalize;
    } cmd_t;

    typedef struct packed {
        logic primed;
        logic loop_ok;
        logic out_free;
    } status_t;

    // 8-bit is offset binary; code 3 decodes as 24-bit
    function automatic sample_t decode_sample(input raw_t raw, input width_t w);
        sample_t s;
        case (w)
            WIDTH_U8:  s = {~raw[7], raw[6:0], {(SAMPLE_BITS-8){1'b0}}};
            WIDTH_S16: s = {raw[15:0], {(SAMPLE_BITS-16){1'b0}}};
            default:   s = raw[SAMPLE_BITS-1:0];
        endcase
        return s;
    endfunction

endpackage

// ----- src/plir_in_if.sv -----
// ----------------------------------------------------------------------------
// plir_in_if
// Input frame channel: valid/ready with raw left and right sample bits.
// ----------------------------------------------------------------------------
interface plir_in_if;
    import plir_pkg::*;

    logic valid;
    logic ready;
    raw_t left_raw;
    raw_t right_raw;

    modport source (output valid, output left_raw, output right_raw, input ready);
    modport sink   (input valid, input left_raw, input right_raw, output ready);
endinterface

// ----- src/plir_out_if.sv -----
// ----------------------------------------------------------------------------
// plir_out_if
// Result channel: valid/ready with interpolated samples and run marker.
// ----------------------------------------------------------------------------
interface plir_out_if;
    import plir_pkg::*;

    logic    valid;
    logic    ready;
    sample_t out_left;
    sample_t out_right;
    logic    last_of_run;

    modport source (output valid, output out_left, output out_right,
                    output last_of_run, input ready);
    modport sink   (input valid, input out_left, input out_right,
                    input last_of_run, output ready);
endinterface

// ----- src/plir_ctrl.sv -----
// ----------------------------------------------------------------------------
// plir_ctrl
// Sequencer: takes a frame, steps the interpolation loop, emits results.
// ----------------------------------------------------------------------------
module plir_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  plir_pkg::status_t status,
    output plir_pkg::cmd_t    cmd
);
    import plir_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    if (status.primed)
                    begin
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_CHECK:
            begin
                if (status.loop_ok)
                begin
                    cmd.step   = 1'b1;
                    state_next = ST_EMIT;
                end
                else
                begin
                    cmd.finalize = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- src/plir_dp.sv -----
// ----------------------------------------------------------------------------
// plir_dp
// Datapath: config registers, decode, frame store, phase, lerp, output reg.
// ----------------------------------------------------------------------------
module plir_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  plir_pkg::cfg_idx_t  cfg_index,
    input  plir_pkg::cfg_data_t cfg_data,
    input  plir_pkg::raw_t      left_raw,
    input  plir_pkg::raw_t      right_raw,
    input  logic                out_ready,
    output logic                out_valid,
    output plir_pkg::sample_t   out_left,
    output plir_pkg::sample_t   out_right,
    output logic                last_of_run,
    input  plir_pkg::cmd_t      cmd,
    output plir_pkg::status_t   status
);
    import plir_pkg::*;

    width_t  width_reg;
    logic    stereo_reg;
    step_t   step_reg;

    logic    primed_reg;
    phase_t  phase_reg;
    logic [CNT_W-1:0] cnt_reg;
    sample_t cur_l_reg;
    sample_t cur_r_reg;
    sample_t prev_l_reg;
    sample_t prev_r_reg;
    logic signed [PROD_W-1:0] prod_l_reg;
    logic signed [PROD_W-1:0] prod_r_reg;
    logic    last_reg;

    logic    out_valid_reg;
    sample_t out_l_reg;
    sample_t out_r_reg;
    logic    out_last_reg;

    sample_t dec_l;
    sample_t dec_r;
    phase_t  phase_sum;
    logic    phase_ge_one;
    logic signed [PROD_W-1:0] frac_ext;
    logic signed [PROD_W-1:0] diff_l;
    logic signed [PROD_W-1:0] diff_r;
    logic signed [PROD_W-1:0] shift_l;
    logic signed [PROD_W-1:0] shift_r;

    assign dec_l = decode_sample(left_raw, width_reg);
    assign dec_r = stereo_reg ? decode_sample(right_raw, width_reg) : dec_l;

    assign phase_ge_one = |phase_reg[PHASE_BITS-1:FRAC_BITS];
    assign phase_sum    = phase_reg + PHASE_BITS'(step_reg);

    assign frac_ext = PROD_W'(phase_reg[FRAC_BITS-1:0]);
    assign diff_l   = PROD_W'(cur_l_reg) - PROD_W'(prev_l_reg);
    assign diff_r   = PROD_W'(cur_r_reg) - PROD_W'(prev_r_reg);
    assign shift_l  = prod_l_reg >>> FRAC_BITS;
    assign shift_r  = prod_r_reg >>> FRAC_BITS;

    assign status.primed   = primed_reg;
    assign status.loop_ok  = !phase_ge_one && !cnt_reg[CNT_W-1];
    assign status.out_free = !out_valid_reg || out_ready;

    assign out_valid   = out_valid_reg;
    assign out_left    = out_l_reg;
    assign out_right   = out_r_reg;
    assign last_of_run = out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= RST_SAMPLE_WIDTH;
            stereo_reg <= RST_STEREO_MODE;
            step_reg   <= RST_PHASE_STEP;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SAMPLE_WIDTH: width_reg  <= cfg_data[1:0];
                CFG_STEREO_MODE:  stereo_reg <= cfg_data[0];
                CFG_PHASE_STEP:   step_reg   <= cfg_data;
                default:          ;
            endcase
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            primed_reg    <= 1'b0;
            phase_reg     <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            prev_l_reg    <= '0;
            prev_r_reg    <= '0;
        end
        else
        begin
            if (cmd.load_in)
            begin
                cnt_reg <= '0;
                if (!primed_reg)
                begin
                    primed_reg <= 1'b1;
                    prev_l_reg <= dec_l;
                    prev_r_reg <= dec_r;
                end
            end
            if (cmd.step)
            begin
                phase_reg <= phase_sum;
                cnt_reg   <= cnt_reg + 1'b1;
            end
            if (cmd.finalize)
            begin
                phase_reg  <= phase_ge_one ? phase_reg - PHASE_BITS'(1 << FRAC_BITS) : '0;
                prev_l_reg <= cur_l_reg;
                prev_r_reg <= cur_r_reg;
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            cur_l_reg <= dec_l;
            cur_r_reg <= dec_r;
        end
        if (cmd.step)
        begin
            prod_l_reg <= diff_l * frac_ext;
            prod_r_reg <= diff_r * frac_ext;
            last_reg   <= (|phase_sum[PHASE_BITS-1:FRAC_BITS])
                          || (cnt_reg == CNT_W'(MAX_RESULTS - 1));
        end
        if (cmd.emit)
        begin
            out_l_reg    <= prev_l_reg + shift_l[SAMPLE_BITS-1:0];
            out_r_reg    <= prev_r_reg + shift_r[SAMPLE_BITS-1:0];
            out_last_reg <= last_reg;
        end
    end

endmodule

// ----- src/pcm_linear_interp_resampler_core.sv -----
// Per result: CHECK registers the difference times the phase fraction, then EMIT loads
// the output register, waiting while it is full. A frame gives up to 64 results from
// the single multiply-then-add step shared by all; a new frame is taken only after its loop.
// A frame is taken while the last result still waits in the output register.
// Reset (rst_n, async, active low): config to 16-bit stereo, unit step; phase,
// previous frame and primed flag cleared; no results pending.
// ----------------------------------------------------------------------------
// pcm_linear_interp_resampler_core
// Linear interpolation sample-rate converter for 8/16/24-bit PCM frames.
// ----------------------------------------------------------------------------
module pcm_linear_interp_resampler_core (
    input  logic                clk,
    input  logic                rst_n,
    plir_in_if.sink             in_ch,
    plir_out_if.source          out_ch,
    input  logic                cfg_we,
    input  plir_pkg::cfg_idx_t  cfg_index,
    input  plir_pkg::cfg_data_t cfg_data
);
    import plir_pkg::*;

    cmd_t    cmd;
    status_t status;

    plir_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .status   (status),
        .cmd      (cmd)
    );

    plir_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .left_raw    (in_ch.left_raw),
        .right_raw   (in_ch.right_raw),
        .out_ready   (out_ch.ready),
        .out_valid   (out_ch.valid),
        .out_left    (out_ch.out_left),
        .out_right   (out_ch.out_right),
        .last_of_run (out_ch.last_of_run),
        .cmd         (cmd),
        .status      (status)
    );

endmodule

// ----- src/plir_checker.sv -----
// ----------------------------------------------------------------------------
// plir_checker
// Port-level checks on the resampler, bound to the top level.
// ----------------------------------------------------------------------------
module plir_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input plir_pkg::sample_t out_left,
    input plir_pkg::sample_t out_right,
    input logic              out_last
);

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_left)
            && $stable(out_right) && $stable(out_last))
        else $error("result changed while stalled");

    // busy only after a frame transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(in_ready) |-> $past(in_valid && in_ready))
        else $error("input ready dropped without a transfer");

    // a run still in progress blocks new frames
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_last |-> !in_ready)
        else $error("frame accepted mid run");

    // after a mid-run transfer another result must follow before idle
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !out_last |=> !in_ready)
        else $error("run ended without last marker");

endmodule

bind pcm_linear_interp_resampler_core plir_checker u_plir_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_left  (out_ch.out_left),
    .out_right (out_ch.out_right),
    .out_last  (out_ch.last_of_run)
);
